[rtl/core/spp_pkg.sv]
// Package for the stack signature profiler: sizes, item types, op, outcome and register codes.
// No dependencies.
`default_nettype none
package spp_pkg;
	localparam int TARGETS     = 4;
	localparam int TGT_W       = 2;
	localparam int SIG_SLOTS   = 16;
	localparam int SLOT_W      = 4;
	localparam int STACK_DEPTH = 8;
	localparam int KW_W        = 3;
	localparam int SCAN_SLOTS  = 64;
	localparam int SEEN_W      = 7;
	localparam int ENT_W       = 64 + 32 + 4;
	localparam int ENT_AW      = TGT_W + SLOT_W;
	localparam int WRD_AW      = TGT_W + SLOT_W + KW_W;

	localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;
	localparam logic [31:0] CNT_MAX   = 32'hFFFF_FFFF;

	localparam logic [1:0] OP_WORD  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [2:0] OC_MATCH     = 3'd0;
	localparam logic [2:0] OC_NEW       = 3'd1;
	localparam logic [2:0] OC_COLLISION = 3'd2;
	localparam logic [2:0] OC_OVERFLOW  = 3'd3;
	localparam logic [2:0] OC_TOTALS    = 3'd4;

	localparam logic [1:0] REG_ENABLE     = 2'd0;
	localparam logic [1:0] REG_RANGE_LOW  = 2'd1;
	localparam logic [1:0] REG_RANGE_HIGH = 2'd2;
	localparam logic [1:0] REG_MAX_GAPS   = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [1:0]  target;
		logic [63:0] stack_word;
		logic        read_fault;
		logic        scan_end;
	} item_t;

	typedef struct packed {
		logic [2:0]  outcome;
		logic [3:0]  slot;
		logic [63:0] signature;
		logic [3:0]  depth;
		logic [31:0] entry_count;
		logic [31:0] calls;
		logic [31:0] faults;
		logic [4:0]  unique_res;
		logic [31:0] overflows;
		logic [31:0] collisions;
	} result_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == CNT_MAX) ? v : v + 32'd1;
	endfunction
endpackage
`default_nettype wire

[rtl/core/spp_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module spp_ram #(
	parameter int W = 64,
	parameter int D = 64,
	parameter int AW = $clog2(D)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/core/spp_fnv.sv]
// Byte-serial FNV-1a-64 unit: folds one 64-bit word into the running hash, one byte a cycle.
// Depends on spp_pkg.
`default_nettype none
module spp_fnv
	import spp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        restart,
	input  wire logic        start,
	input  wire logic [63:0] word,
	output logic      [63:0] hash,
	output logic             busy
);
	logic [63:0] hash_q, word_q, x;
	logic [3:0]  cnt_q;

	// multiply by 2^40 + 0x1B3
	assign x = hash_q ^ {56'd0, word_q[7:0]};
	assign hash = hash_q;
	assign busy = (cnt_q != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= FNV_BASIS;
			cnt_q  <= 4'd0;
		end else if (restart) begin
			hash_q <= FNV_BASIS;
			cnt_q  <= 4'd0;
		end else if (start) begin
			cnt_q <= 4'd8;
		end else if (busy) begin
			hash_q <= (x << 40) + x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8);
			cnt_q  <= cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			word_q <= word;
		end else if (busy) begin
			word_q <= word_q >> 8;
		end
	end
endmodule
`default_nettype wire

[rtl/core/stack_signature_profiler.sv]
// Stack signature profiler top level: scan capture, signature table search and per-target totals.
// Depends on spp_pkg, spp_fnv, spp_ram.
// A kept word is hashed byte by byte in the FNV unit (ST_HASH); other words skip ST_HASH.
// Scan end: per entry ST_RD, ST_CMP; per word compared ST_WRD, ST_WCHK; per word written ST_NEW.
// One transaction in flight at a time; totals read and clear go from idle straight to ST_OUT.
// Reset (arst_n low) clears config, scan state and totals; table contents stay undefined.
`default_nettype none
module stack_signature_profiler
	import spp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire item_t       item,
	output logic             result_valid,
	input  wire logic        result_ready,
	output result_t          result,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_HASH = 9'b000000010,
		ST_FIN  = 9'b000000100,
		ST_RD   = 9'b000001000,
		ST_CMP  = 9'b000010000,
		ST_WRD  = 9'b000100000,
		ST_WCHK = 9'b001000000,
		ST_NEW  = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	state_t state_q;

	logic        enable_q;
	logic [63:0] range_low_q, range_high_q;
	logic [7:0]  max_gaps_q;

	logic [SEEN_W-1:0] slots_seen_q;
	logic [3:0]        kept_q;
	logic [7:0]        miss_q;
	logic              stopped_q;
	logic [63:0]       kept_words_q [STACK_DEPTH];

	logic [4:0]  used_q [TARGETS];
	logic [31:0] calls_q [TARGETS];
	logic [31:0] faults_q [TARGETS];
	logic [31:0] ovf_q [TARGETS];
	logic [31:0] coll_q [TARGETS];

	logic [TGT_W-1:0] t_q;
	logic             cf_q, end_q, stat_q;
	logic [4:0]       i_q;
	logic [KW_W-1:0]  k_q;
	logic [2:0]       outcome_q;
	logic [3:0]       slot_q;
	logic [31:0]      count_q;

	logic [63:0] hash;
	logic        hash_busy, hash_start, hash_restart;

	logic             ent_we, wrd_we;
	logic [ENT_W-1:0] ent_wdata, ent_rdata;
	logic [ENT_AW-1:0] ent_waddr;
	logic [WRD_AW-1:0] wrd_waddr;
	logic [63:0]      wrd_rdata;
	logic [63:0]      ent_hash;
	logic [31:0]      ent_hits;
	logic [3:0]       ent_depth;

	logic accept, take, hit, finish, restart_scan;
	logic [3:0]        kept_nx;
	logic [SEEN_W-1:0] seen_nx;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = (state_q == ST_OUT);
	assign accept       = item_valid && item_ready;

	assign take    = !stopped_q && !item.read_fault;
	assign hit     = (item.stack_word >= range_low_q) && (item.stack_word <= range_high_q);
	assign finish  = item.read_fault || item.scan_end;
	assign kept_nx = kept_q + {3'd0, take && hit};
	assign seen_nx = slots_seen_q + {{(SEEN_W-1){1'b0}}, take};

	assign hash_start   = accept && (item.op == OP_WORD) && enable_q && take && hit;
	assign restart_scan = (accept && (item.op == OP_CLEAR))
		|| (result_valid && result_ready && !stat_q);
	assign hash_restart = restart_scan;

	assign {ent_hash, ent_hits, ent_depth} = ent_rdata;

	spp_fnv u_fnv (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (hash_restart),
		.start   (hash_start),
		.word    (item.stack_word),
		.hash    (hash),
		.busy    (hash_busy)
	);

	spp_ram #(.W(ENT_W), .D(TARGETS * SIG_SLOTS)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr ({t_q, i_q[SLOT_W-1:0]}),
		.rdata (ent_rdata)
	);

	spp_ram #(.W(64), .D(TARGETS * SIG_SLOTS * STACK_DEPTH)) u_wrd_ram (
		.clk   (clk),
		.we    (wrd_we),
		.waddr (wrd_waddr),
		.wdata (kept_words_q[k_q]),
		.raddr ({t_q, i_q[SLOT_W-1:0], k_q}),
		.rdata (wrd_rdata)
	);

	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = {t_q, i_q[SLOT_W-1:0]};
		ent_wdata = {hash, 32'd1, kept_q};
		wrd_we    = (state_q == ST_NEW);
		wrd_waddr = {t_q, slot_q, k_q};
		case (state_q)
			ST_RD: begin
				ent_we = (i_q >= used_q[t_q]) && (used_q[t_q] < 5'(SIG_SLOTS));
			end
			ST_CMP: begin
				ent_we    = (ent_hash == hash) && (ent_depth == kept_q) && (kept_q == 4'd0);
				ent_wdata = {ent_hash, sat_inc(ent_hits), ent_depth};
			end
			ST_WCHK: begin
				ent_we    = (wrd_rdata == kept_words_q[k_q]) && ({1'b0, k_q} == kept_q - 4'd1);
				ent_wdata = {ent_hash, sat_inc(ent_hits), ent_depth};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			range_low_q  <= 64'd0;
			range_high_q <= 64'd0;
			max_gaps_q   <= 8'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:     enable_q     <= cfg_data[0];
				REG_RANGE_LOW:  range_low_q  <= cfg_data;
				REG_RANGE_HIGH: range_high_q <= cfg_data;
				REG_MAX_GAPS:   max_gaps_q   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (hash_start && (kept_q < 4'(STACK_DEPTH))) begin
			kept_words_q[kept_q[KW_W-1:0]] <= item.stack_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slots_seen_q <= '0;
			kept_q       <= 4'd0;
			miss_q       <= 8'd0;
			stopped_q    <= 1'b0;
			t_q          <= '0;
			cf_q         <= 1'b0;
			end_q        <= 1'b0;
			stat_q       <= 1'b0;
			i_q          <= 5'd0;
			k_q          <= '0;
			outcome_q    <= OC_TOTALS;
			slot_q       <= 4'd0;
			count_q      <= 32'd0;
			for (int j = 0; j < TARGETS; j++) begin
				used_q[j]   <= 5'd0;
				calls_q[j]  <= 32'd0;
				faults_q[j] <= 32'd0;
				ovf_q[j]    <= 32'd0;
				coll_q[j]   <= 32'd0;
			end
		end else begin
			if (restart_scan) begin
				slots_seen_q <= '0;
				kept_q       <= 4'd0;
				miss_q       <= 8'd0;
				stopped_q    <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						t_q <= item.target;
						case (item.op)
							OP_WORD: begin
								if (enable_q) begin
									cf_q  <= item.read_fault && !stopped_q;
									end_q <= finish;
									stat_q <= 1'b0;
									if (take) begin
										kept_q       <= kept_nx;
										slots_seen_q <= seen_nx;
										if (hit) begin
											miss_q <= 8'd0;
										end else if ((kept_q != 4'd0)
											&& (miss_q < max_gaps_q)) begin
											miss_q <= miss_q + 8'd1;
										end
										if ((kept_nx >= 4'(STACK_DEPTH))
											|| (seen_nx >= SEEN_W'(SCAN_SLOTS))
											|| (!hit && (kept_q != 4'd0)
											&& (miss_q >= max_gaps_q))) begin
											stopped_q <= 1'b1;
										end
									end
									if (take && hit) begin
										state_q <= ST_HASH;
									end else if (finish) begin
										state_q <= ST_FIN;
									end
								end
							end
							OP_READ: begin
								stat_q  <= 1'b1;
								state_q <= ST_OUT;
							end
							OP_CLEAR: begin
								stat_q  <= 1'b1;
								state_q <= ST_OUT;
								for (int j = 0; j < TARGETS; j++) begin
									used_q[j]   <= 5'd0;
									calls_q[j]  <= 32'd0;
									faults_q[j] <= 32'd0;
									ovf_q[j]    <= 32'd0;
									coll_q[j]   <= 32'd0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_HASH: begin
					if (!hash_busy) begin
						state_q <= end_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_FIN: begin
					calls_q[t_q] <= sat_inc(calls_q[t_q]);
					if (cf_q) begin
						faults_q[t_q] <= sat_inc(faults_q[t_q]);
					end
					i_q     <= 5'd0;
					state_q <= ST_RD;
				end
				ST_RD: begin
					k_q <= '0;
					if (i_q >= used_q[t_q]) begin
						if (used_q[t_q] >= 5'(SIG_SLOTS)) begin
							ovf_q[t_q] <= sat_inc(ovf_q[t_q]);
							outcome_q  <= OC_OVERFLOW;
							slot_q     <= 4'd0;
							count_q    <= 32'd0;
							state_q    <= ST_OUT;
						end else begin
							used_q[t_q] <= used_q[t_q] + 5'd1;
							outcome_q   <= OC_NEW;
							slot_q      <= i_q[SLOT_W-1:0];
							count_q     <= 32'd1;
							state_q     <= (kept_q == 4'd0) ? ST_OUT : ST_NEW;
						end
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (ent_hash != hash) begin
						i_q     <= i_q + 5'd1;
						state_q <= ST_RD;
					end else if (ent_depth != kept_q) begin
						coll_q[t_q] <= sat_inc(coll_q[t_q]);
						outcome_q   <= OC_COLLISION;
						slot_q      <= 4'd0;
						count_q     <= 32'd0;
						state_q     <= ST_OUT;
					end else if (kept_q == 4'd0) begin
						outcome_q <= OC_MATCH;
						slot_q    <= i_q[SLOT_W-1:0];
						count_q   <= sat_inc(ent_hits);
						state_q   <= ST_OUT;
					end else begin
						state_q <= ST_WRD;
					end
				end
				ST_WRD: begin
					state_q <= ST_WCHK;
				end
				ST_WCHK: begin
					if (wrd_rdata != kept_words_q[k_q]) begin
						coll_q[t_q] <= sat_inc(coll_q[t_q]);
						outcome_q   <= OC_COLLISION;
						slot_q      <= 4'd0;
						count_q     <= 32'd0;
						state_q     <= ST_OUT;
					end else if ({1'b0, k_q} == kept_q - 4'd1) begin
						outcome_q <= OC_MATCH;
						slot_q    <= i_q[SLOT_W-1:0];
						count_q   <= sat_inc(ent_hits);
						state_q   <= ST_OUT;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_WRD;
					end
				end
				ST_NEW: begin
					if ({1'b0, k_q} == kept_q - 4'd1) begin
						state_q <= ST_OUT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (result_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		result.outcome     = stat_q ? OC_TOTALS : outcome_q;
		result.slot        = stat_q ? 4'd0 : slot_q;
		result.signature   = stat_q ? 64'd0 : hash;
		result.depth       = stat_q ? 4'd0 : kept_q;
		result.entry_count = stat_q ? 32'd0 : count_q;
		result.calls       = calls_q[t_q];
		result.faults      = faults_q[t_q];
		result.unique_res  = used_q[t_q];
		result.overflows   = ovf_q[t_q];
		result.collisions  = coll_q[t_q];
	end
endmodule
`default_nettype wire

[rtl/core/spp_checker.sv]
// Port-level checker for the stack signature profiler, bound to the top level.
// Depends on spp_pkg and stack_signature_profiler.
`default_nettype none
module spp_checker
	import spp_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    result_valid,
	input wire logic    result_ready,
	input wire result_t result
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result dropped or changed while stalled");

	a_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.outcome == OC_MATCH) || (result.outcome == OC_NEW)
			|| (result.outcome == OC_COLLISION) || (result.outcome == OC_OVERFLOW)
			|| (result.outcome == OC_TOTALS))
		else $error("bad outcome");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.unique_res <= 5'd16) && (result.depth <= 4'd8))
		else $error("entry count or depth out of range");

	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.outcome == OC_TOTALS) |->
			(result.signature == 64'd0) && (result.depth == 4'd0)
			&& (result.entry_count == 32'd0) && (result.slot == 4'd0))
		else $error("totals transaction carries scan fields");
endmodule

bind stack_signature_profiler spp_checker u_spp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
`default_nettype wire

[test/tb.sv]
// Testbench for stack_signature_profiler: directed and random stack scans, totals reads
// and clears, checked against an in-bench predictor of the signature table.
// Depends on spp_pkg and the profiler RTL.
`default_nettype none
module tb;
	import spp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
	localparam logic [1:0]  OP_NONE   = 2'd3;
	localparam int          SETTLE    = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_ENABLE;
	logic [63:0] cfg_data = '0;

	stack_signature_profiler dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic        p_enable;
	logic [63:0] p_low, p_high;
	logic [7:0]  p_gaps;
	logic [6:0]  p_seen;
	logic [3:0]  p_kept;
	logic [7:0]  p_miss;
	logic        p_stopped;
	logic [63:0] p_hash;
	logic [63:0] p_kept_words [STACK_DEPTH];
	logic [63:0] p_ent_hash [TARGETS*SIG_SLOTS];
	logic [31:0] p_ent_hits [TARGETS*SIG_SLOTS];
	logic [3:0]  p_ent_depth [TARGETS*SIG_SLOTS];
	logic [63:0] p_ent_words [TARGETS*SIG_SLOTS*STACK_DEPTH];
	logic [4:0]  p_used [TARGETS];
	logic [31:0] p_calls [TARGETS];
	logic [31:0] p_faults [TARGETS];
	logic [31:0] p_ovf [TARGETS];
	logic [31:0] p_coll [TARGETS];

	result_t expected_results [$];
	int      mismatches = 0;
	int      checked = 0;
	int      items_sent = 0;
	int      outcome_seen [8];
	bit      calm = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb: errors");
		$finish;
	end

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic void restart_scan();
		p_seen = '0;
		p_kept = '0;
		p_miss = '0;
		p_stopped = 1'b0;
		p_hash = FNV_BASIS;
	endfunction

	function automatic void clear_tables();
		for (int i = 0; i < TARGETS*SIG_SLOTS; i++) begin
			p_ent_hash[i] = '0;
			p_ent_hits[i] = '0;
			p_ent_depth[i] = '0;
		end
		for (int i = 0; i < TARGETS*SIG_SLOTS*STACK_DEPTH; i++) p_ent_words[i] = '0;
		for (int t = 0; t < TARGETS; t++) begin
			p_used[t] = '0;
			p_calls[t] = '0;
			p_faults[t] = '0;
			p_ovf[t] = '0;
			p_coll[t] = '0;
		end
	endfunction

	function automatic void fold_word(input logic [63:0] w);
		if (w >= p_low && w <= p_high) begin
			if (p_kept < STACK_DEPTH) p_kept_words[p_kept] = w;
			p_kept++;
			p_miss = '0;
			for (int b = 0; b < 8; b++) begin
				p_hash = p_hash ^ {56'd0, w[b*8 +: 8]};
				p_hash = p_hash * FNV_PRIME;
			end
		end else if (p_kept > 0) begin
			if (p_miss >= p_gaps) p_stopped = 1'b1;
			else p_miss++;
		end
		p_seen++;
		if (p_kept >= STACK_DEPTH || p_seen >= SCAN_SLOTS) p_stopped = 1'b1;
	endfunction

	function automatic void fill_totals(inout result_t r, input int t);
		r.calls = p_calls[t];
		r.faults = p_faults[t];
		r.unique_res = p_used[t];
		r.overflows = p_ovf[t];
		r.collisions = p_coll[t];
	endfunction

	function automatic result_t book_signature(input int t);
		result_t r;
		int base;
		bit done, same;
		int e;
		r = '0;
		base = t * SIG_SLOTS;
		done = 1'b0;
		r.outcome = OC_OVERFLOW;
		p_calls[t] = bump(p_calls[t]);
		for (int i = 0; i < p_used[t] && !done; i++) begin
			e = base + i;
			if (p_ent_hash[e] == p_hash) begin
				same = (p_ent_depth[e] == p_kept);
				for (int k = 0; same && k < p_kept; k++)
					if (p_ent_words[e*STACK_DEPTH + k] != p_kept_words[k]) same = 1'b0;
				if (same) begin
					p_ent_hits[e] = bump(p_ent_hits[e]);
					r.outcome = OC_MATCH;
					r.slot = 4'(i);
					r.entry_count = p_ent_hits[e];
				end else begin
					p_coll[t] = bump(p_coll[t]);
					r.outcome = OC_COLLISION;
				end
				done = 1'b1;
			end
		end
		if (!done) begin
			if (p_used[t] >= SIG_SLOTS) begin
				p_ovf[t] = bump(p_ovf[t]);
			end else begin
				e = base + p_used[t];
				p_ent_hash[e] = p_hash;
				p_ent_hits[e] = 32'd1;
				p_ent_depth[e] = p_kept;
				for (int k = 0; k < p_kept; k++)
					p_ent_words[e*STACK_DEPTH + k] = p_kept_words[k];
				r.outcome = OC_NEW;
				r.slot = p_used[t][3:0];
				r.entry_count = 32'd1;
				p_used[t]++;
			end
		end
		r.signature = p_hash;
		r.depth = p_kept;
		fill_totals(r, t);
		return r;
	endfunction

	function automatic void predict_item(input item_t it);
		result_t r;
		bit counted;
		r = '0;
		case (it.op)
			OP_WORD: begin
				if (p_enable) begin
					counted = it.read_fault && !p_stopped;
					if (!p_stopped && !it.read_fault) fold_word(it.stack_word);
					if (it.read_fault || it.scan_end) begin
						if (counted) p_faults[it.target] = bump(p_faults[it.target]);
						expected_results.push_back(book_signature(it.target));
						restart_scan();
					end
				end
			end
			OP_READ: begin
				r.outcome = OC_TOTALS;
				fill_totals(r, it.target);
				expected_results.push_back(r);
			end
			OP_CLEAR: begin
				clear_tables();
				restart_scan();
				r.outcome = OC_TOTALS;
				expected_results.push_back(r);
			end
			default: ;
		endcase
	endfunction

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 20);
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [1:0] tgt,
			input logic [63:0] w, input bit fault, input bit last);
		item_t it;
		it = '{op: op, target: tgt, stack_word: w, read_fault: fault, scan_end: last};
		while (idle_now()) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		predict_item(it);
		items_sent++;
	endtask

	task automatic send_scan(input logic [1:0] tgt, input logic [63:0] words [$]);
		foreach (words[i]) send_item(OP_WORD, tgt, words[i], 1'b0, i == words.size() - 1);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_regs(input logic en, input logic [63:0] lo, input logic [63:0] hi,
			input logic [7:0] gaps);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_ENABLE; cfg_data <= {63'd0, en};
		@(posedge clk);
		cfg_index <= REG_RANGE_LOW; cfg_data <= lo;
		@(posedge clk);
		cfg_index <= REG_RANGE_HIGH; cfg_data <= hi;
		@(posedge clk);
		cfg_index <= REG_MAX_GAPS; cfg_data <= {56'd0, gaps};
		@(posedge clk);
		cfg_we <= 1'b0;
		p_enable = en; p_low = lo; p_high = hi; p_gaps = gaps;
	endtask

	task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a,
			inout bit bad);
		if (e !== a) begin
			if (mismatches < 10)
				$display("mismatch #%0d %s: expected %h got %h", mismatches, name, e, a);
			bad = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		result_t e;
		bit bad;
		if (arst_n && result_valid && result_ready) begin
			checked++;
			if (expected_results.size() == 0) begin
				if (mismatches < 10) $display("unexpected transaction: %p", result);
				mismatches++;
			end else begin
				e = expected_results.pop_front();
				bad = 1'b0;
				outcome_seen[e.outcome]++;
				check_field("outcome", e.outcome, result.outcome, bad);
				check_field("slot", e.slot, result.slot, bad);
				check_field("signature", e.signature, result.signature, bad);
				check_field("depth", e.depth, result.depth, bad);
				check_field("entry_count", e.entry_count, result.entry_count, bad);
				check_field("calls", e.calls, result.calls, bad);
				check_field("faults", e.faults, result.faults, bad);
				check_field("unique_res", e.unique_res, result.unique_res, bad);
				check_field("overflows", e.overflows, result.overflows, bad);
				check_field("collisions", e.collisions, result.collisions, bad);
				if (bad) mismatches++;
			end
		end
		result_ready <= calm || ($urandom_range(99) >= 20);
	end

	task automatic test_disabled();
		send_item(OP_WORD, 2'd0, 64'h1000, 1'b0, 1'b1);
		send_item(OP_WORD, 2'd1, 64'h0, 1'b1, 1'b0);
		send_item(OP_NONE, 2'd2, '1, 1'b1, 1'b1);
		send_item(OP_READ, 2'd0, '0, 1'b0, 1'b0);
	endtask

	task automatic test_basic_scan();
		set_regs(1'b1, 64'h1000, 64'h1FFF, 8'd8);
		send_scan(2'd0, '{64'h1000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1FFF, 64'h0});
		send_scan(2'd0, '{64'h1000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1FFF, 64'h0});
		send_scan(2'd1, '{64'h0FFF, 64'h2000});
		send_item(OP_READ, 2'd0, '0, 1'b0, 1'b0);
		send_item(OP_READ, 2'd3, '1, 1'b1, 1'b1);
	endtask

	task automatic test_caps();
		logic [63:0] words [$];
		send_scan(2'd2, '{64'h1001, 64'h1002, 64'h1003, 64'h1004, 64'h1005,
			64'h1006, 64'h1007, 64'h1008, 64'h1009, 64'h100A});
		words = {};
		for (int i = 0; i < SCAN_SLOTS + 3; i++) words.push_back(64'h5);
		words[SCAN_SLOTS + 1] = 64'h1234;
		send_scan(2'd2, words);
		set_regs(1'b1, 64'h1000, 64'h1FFF, 8'd0);
		send_scan(2'd3, '{64'h0, 64'h1100, 64'h7, 64'h1200, 64'h1300});
		set_regs(1'b1, 64'h1000, 64'h1FFF, 8'd255);
		send_scan(2'd3, '{64'h1100, 64'h7, 64'h8, 64'h9, 64'h1200});
	endtask

	task automatic test_faults();
		send_item(OP_WORD, 2'd1, 64'h1111, 1'b1, 1'b0);
		send_item(OP_WORD, 2'd1, 64'h1111, 1'b0, 1'b0);
		send_item(OP_WORD, 2'd1, 64'h1112, 1'b1, 1'b1);
		for (int i = 0; i < STACK_DEPTH; i++) send_item(OP_WORD, 2'd1, 64'h1500 + i, 1'b0, 1'b0);
		send_item(OP_WORD, 2'd1, 64'h1, 1'b1, 1'b0);
		send_item(OP_READ, 2'd1, '0, 1'b0, 1'b0);
	endtask

	task automatic test_clear_and_windows();
		send_item(OP_WORD, 2'd0, 64'h1400, 1'b0, 1'b0);
		send_item(OP_CLEAR, 2'd0, '0, 1'b0, 1'b0);
		send_scan(2'd0, '{64'h1401});
		set_regs(1'b1, 64'h0, '1, 8'd8);
		send_scan(2'd0, '{64'h0, '1});
		set_regs(1'b1, 64'hFFFF, 64'h1, 8'd8);
		send_scan(2'd0, '{64'h10, 64'h8000});
	endtask

	task automatic test_overflow();
		set_regs(1'b1, 64'h1000, 64'h1FFF, 8'd8);
		for (int i = 0; i < SIG_SLOTS + 3; i++) send_scan(2'd3, '{64'h1000 + i});
		send_scan(2'd3, '{64'h1000});
		send_item(OP_READ, 2'd3, '0, 1'b0, 1'b0);
	endtask

	task automatic run_random_phase(input int count, input logic [63:0] lo,
			input logic [63:0] hi);
		logic [63:0] pool [16][10];
		int          pool_len [16];
		logic [1:0]  tgt;
		int          n, sel, r;
		logic [63:0] w;
		for (int s = 0; s < 16; s++) begin
			pool_len[s] = $urandom_range(1, 10);
			for (int k = 0; k < 10; k++)
				pool[s][k] = ($urandom_range(3) == 0) ? {$urandom, $urandom}
					: lo + {$urandom_range(255), 3'd0};
		end
		n = 0;
		while (n < count) begin
			calm = (n > count / 3) && (n < count / 2);
			r = $urandom_range(99);
			tgt = $urandom_range(3);
			if (r < 70) begin
				sel = $urandom_range(15);
				for (int k = 0; k < pool_len[sel]; k++) begin
					send_item(OP_WORD, tgt, pool[sel][k], 1'b0, k == pool_len[sel] - 1);
					n++;
				end
			end else if (r < 85) begin
				do begin
					w = ($urandom_range(1)) ? {$urandom, $urandom}
						: (($urandom_range(1)) ? lo + $urandom_range(4095)
						: hi - $urandom_range(4095));
					send_item(OP_WORD, tgt, w, $urandom_range(19) == 0,
						$urandom_range(5) == 0);
					n++;
				end while (item.read_fault == 1'b0 && item.scan_end == 1'b0);
			end else if (r < 94) begin
				send_item(OP_READ, tgt, {$urandom, $urandom}, $urandom_range(1),
					$urandom_range(1));
				n++;
			end else if (r < 97) begin
				send_item(OP_NONE, tgt, {$urandom, $urandom}, $urandom_range(1),
					$urandom_range(1));
				n++;
			end else begin
				send_item(OP_CLEAR, tgt, {$urandom, $urandom}, $urandom_range(1),
					$urandom_range(1));
				n++;
			end
		end
		calm = 1'b0;
	endtask

	task automatic test_random();
		set_regs(1'b1, 64'h4000_0000_0000, 64'h4000_0000_0FFF, 8'd3);
		run_random_phase(450, 64'h4000_0000_0000, 64'h4000_0000_0FFF);
		set_regs(1'b1, 64'h8000, 64'hFFFF, 8'd0);
		run_random_phase(300, 64'h8000, 64'hFFFF);
		set_regs(1'b1, 64'h0, '1, 8'd255);
		run_random_phase(200, 64'h0, '1);
		set_regs(1'b0, 64'h8000, 64'hFFFF, 8'd8);
		run_random_phase(80, 64'h8000, 64'hFFFF);
		set_regs(1'b1, 64'hFFFF_FFFF_FFFF_F000, '1, 8'd8);
		run_random_phase(120, 64'hFFFF_FFFF_FFFF_F000, '1);
	endtask

	initial begin
		p_enable = 1'b0; p_low = '0; p_high = '0; p_gaps = 8'd8;
		for (int i = 0; i < STACK_DEPTH; i++) p_kept_words[i] = '0;
		restart_scan();
		clear_tables();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_disabled();
		test_basic_scan();
		test_caps();
		test_faults();
		test_clear_and_windows();
		test_overflow();
		test_random();
		drain();
		$display("%0d items sent, %0d results checked", items_sent, checked);
		$display("matched %0d, new %0d, collision %0d, overflow %0d, totals %0d",
			outcome_seen[OC_MATCH], outcome_seen[OC_NEW], outcome_seen[OC_COLLISION],
			outcome_seen[OC_OVERFLOW], outcome_seen[OC_TOTALS]);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
